// ----- rtl/core/aavr_pkg.sv -----
`default_nettype none
package aavr_pkg;

	localparam int CordicStepsDef = 16;
	localparam int AtanCount      = 24;

	localparam int CorW = 34;  // CORDIC x, y in Q.30 plus headroom
	localparam int AngW = 33;  // residual angle, 2^-32 turn
	localparam int ScW  = 26;  // sine, cosine in Q.24
	localparam int WW   = 28;  // scaled axis in Q.24
	localparam int P1W  = 60;  // w * p
	localparam int TW   = 40;  // t in point format
	localparam int P2W  = 68;  // c * t, w * t
	localparam int AccW = 70;
	localparam int ResW = 47;

	localparam logic signed [CorW-1:0] CordicGain  = CorW'(652032874);
	localparam logic signed [AngW-1:0] QuarterTurn = AngW'(1073741824);

	function automatic logic signed [AngW-1:0] atan_val(input int idx);
		logic signed [AngW-1:0] v;
		unique case (idx)
			0:  v = AngW'(536870912);
			1:  v = AngW'(316933406);
			2:  v = AngW'(167458907);
			3:  v = AngW'(85004756);
			4:  v = AngW'(42667331);
			5:  v = AngW'(21354465);
			6:  v = AngW'(10679838);
			7:  v = AngW'(5340245);
			8:  v = AngW'(2670163);
			9:  v = AngW'(1335087);
			10: v = AngW'(667544);
			11: v = AngW'(333772);
			12: v = AngW'(166886);
			13: v = AngW'(83443);
			14: v = AngW'(41722);
			15: v = AngW'(20861);
			16: v = AngW'(10430);
			17: v = AngW'(5215);
			18: v = AngW'(2608);
			19: v = AngW'(1304);
			20: v = AngW'(652);
			21: v = AngW'(326);
			22: v = AngW'(163);
			23: v = AngW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/axis_angle_vector_rotation.sv -----
`default_nettype none
// Rotates a Q16.16 point about a Q1.14 unit axis by a 16-bit binary angle
// (65536 = one turn), Rodrigues form: t = 2(w x p), p + c*t + w x t, with
// sine and cosine of the half angle from a CORDIC pipeline of CORDIC_STEPS
// stages. One word enters per clock unless the output stalls; a word passes
// the input register, the CORDIC stages and then the multiply and sum stages.
// Results saturate to 32 bits and raise clipped. A stall on the output
// freezes the whole pipeline and is passed back as point_stall.
module axis_angle_vector_rotation
	import aavr_pkg::*;
#(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               point_valid,
	output logic                    point_stall,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic signed [15:0] axis_x,
	input  wire logic signed [15:0] axis_y,
	input  wire logic signed [15:0] axis_z,
	input  wire logic        [15:0] turn_angle,
	output logic                    rotated_valid,
	input  wire logic               rotated_stall,
	output logic signed [31:0]      rotated_x,
	output logic signed [31:0]      rotated_y,
	output logic signed [31:0]      rotated_z,
	output logic                    clipped
);

	localparam int NS = CORDIC_STEPS;

	logic en;
	assign en          = !rotated_valid || !rotated_stall;
	assign point_stall = !en;

	// stage 1 + cordic chain: index 0 is the input register
	logic signed [CorW-1:0] cx_s2 [NS+1];
	logic signed [CorW-1:0] cy_s2 [NS+1];
	logic signed [AngW-1:0] cz_s2 [NS+1];
	logic signed [31:0]     p_s2  [NS+1][3];
	logic signed [15:0]     a_s2  [NS+1][3];
	logic                   v_s2  [NS+1];

	logic signed [AngW-1:0] z_in;
	assign z_in = signed'({2'b00, turn_angle, 15'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_in >= QuarterTurn) begin
				cx_s2[0] <= '0;
				cy_s2[0] <= CordicGain;
				cz_s2[0] <= z_in - QuarterTurn;
			end else begin
				cx_s2[0] <= CordicGain;
				cy_s2[0] <= '0;
				cz_s2[0] <= z_in;
			end
			p_s2[0][0] <= point_x;
			p_s2[0][1] <= point_y;
			p_s2[0][2] <= point_z;
			a_s2[0][0] <= axis_x;
			a_s2[0][1] <= axis_y;
			a_s2[0][2] <= axis_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2[0] <= 1'b0;
		end else if (en) begin
			v_s2[0] <= point_valid;
		end
	end

	for (genvar gi = 0; gi < NS; gi++) begin : g_cor
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s2[gi][AngW-1]) begin
					cx_s2[gi+1] <= cx_s2[gi] - (cy_s2[gi] >>> gi);
					cy_s2[gi+1] <= cy_s2[gi] + (cx_s2[gi] >>> gi);
					cz_s2[gi+1] <= cz_s2[gi] - atan_val(gi);
				end else begin
					cx_s2[gi+1] <= cx_s2[gi] + (cy_s2[gi] >>> gi);
					cy_s2[gi+1] <= cy_s2[gi] - (cx_s2[gi] >>> gi);
					cz_s2[gi+1] <= cz_s2[gi] + atan_val(gi);
				end
				p_s2[gi+1] <= p_s2[gi];
				a_s2[gi+1] <= a_s2[gi];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[gi+1] <= 1'b0;
			end else if (en) begin
				v_s2[gi+1] <= v_s2[gi];
			end
		end
	end

	// stage 3: round sine / cosine to Q.24
	logic signed [ScW-1:0] s_s3, c_s3;
	logic signed [31:0]    p_s3 [3];
	logic signed [15:0]    a_s3 [3];
	logic signed [CorW-1:0] xr, yr;
	assign xr = (cx_s2[NS] + CorW'(32)) >>> 6;
	assign yr = (cy_s2[NS] + CorW'(32)) >>> 6;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3 <= xr[ScW-1:0];
			s_s3 <= yr[ScW-1:0];
			p_s3 <= p_s2[NS];
			a_s3 <= a_s2[NS];
		end
	end

	// stage 4: w = round(axis * s / 2^14)
	logic signed [WW-1:0]  w_s4 [3];
	logic signed [ScW-1:0] c_s4;
	logic signed [31:0]    p_s4 [3];
	logic signed [41:0]    aw   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			aw[k] = (42'(signed'(a_s3[k])) * 42'(s_s3) + 42'(8192)) >>> 14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				w_s4[k] <= aw[k][WW-1:0];
			end
			c_s4 <= c_s3;
			p_s4 <= p_s3;
		end
	end

	// stage 5: cross products w x p
	logic signed [P1W-1:0] mp_s5 [3];
	logic signed [P1W-1:0] mn_s5 [3];
	logic signed [WW-1:0]  w_s5  [3];
	logic signed [ScW-1:0] c_s5;
	logic signed [31:0]    p_s5  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s5[0] <= P1W'(w_s4[1]) * P1W'(p_s4[2]);
			mn_s5[0] <= P1W'(w_s4[2]) * P1W'(p_s4[1]);
			mp_s5[1] <= P1W'(w_s4[2]) * P1W'(p_s4[0]);
			mn_s5[1] <= P1W'(w_s4[0]) * P1W'(p_s4[2]);
			mp_s5[2] <= P1W'(w_s4[0]) * P1W'(p_s4[1]);
			mn_s5[2] <= P1W'(w_s4[1]) * P1W'(p_s4[0]);
			w_s5 <= w_s4;
			c_s5 <= c_s4;
			p_s5 <= p_s4;
		end
	end

	// stage 6: t = round(2 (w x p)) in point format
	logic signed [TW-1:0]  t_s6 [3];
	logic signed [WW-1:0]  w_s6 [3];
	logic signed [ScW-1:0] c_s6;
	logic signed [31:0]    p_s6 [3];
	logic signed [P1W:0]   td   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			td[k] = ((P1W+1)'(mp_s5[k]) - (P1W+1)'(mn_s5[k]) + (P1W+1)'(64'sd4194304))
				>>> 23;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t_s6[k] <= td[k][TW-1:0];
			end
			w_s6 <= w_s5;
			c_s6 <= c_s5;
			p_s6 <= p_s5;
		end
	end

	// stage 7: c*t and w x t products
	logic signed [P2W-1:0] mc_s7 [3];
	logic signed [P2W-1:0] mp_s7 [3];
	logic signed [P2W-1:0] mn_s7 [3];
	logic signed [31:0]    p_s7  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mc_s7[k] <= P2W'(c_s6) * P2W'(t_s6[k]);
			end
			mp_s7[0] <= P2W'(w_s6[1]) * P2W'(t_s6[2]);
			mn_s7[0] <= P2W'(w_s6[2]) * P2W'(t_s6[1]);
			mp_s7[1] <= P2W'(w_s6[2]) * P2W'(t_s6[0]);
			mn_s7[1] <= P2W'(w_s6[0]) * P2W'(t_s6[2]);
			mp_s7[2] <= P2W'(w_s6[0]) * P2W'(t_s6[1]);
			mn_s7[2] <= P2W'(w_s6[1]) * P2W'(t_s6[0]);
			p_s7 <= p_s6;
		end
	end

	// valid for the fixed stages 3..7
	logic [4:0] vt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vt_q <= '0;
		end else if (en) begin
			vt_q <= {vt_q[3:0], v_s2[NS]};
		end
	end

	// output stage: sum, round, add point, saturate
	logic signed [AccW-1:0] acc  [3];
	logic signed [ResW-1:0] res  [3];
	logic signed [31:0]     sat  [3];
	logic       [2:0]       clip;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = AccW'(mc_s7[k]) + AccW'(mp_s7[k]) - AccW'(mn_s7[k])
				+ AccW'(64'sd8388608);
			res[k] = ResW'(p_s7[k]) + ResW'(signed'(acc[k][AccW-1:24]));
			clip[k] = 1'b1;
			if (res[k] > ResW'(64'sd2147483647)) begin
				sat[k] = 32'sh7FFFFFFF;
			end else if (res[k] < -ResW'(64'sd2147483648)) begin
				sat[k] = 32'sh80000000;
			end else begin
				sat[k]  = res[k][31:0];
				clip[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rotated_x <= sat[0];
			rotated_y <= sat[1];
			rotated_z <= sat[2];
			clipped   <= |clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotated_valid <= 1'b0;
		end else if (en) begin
			rotated_valid <= vt_q[4];
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top
	import aavr_pkg::*;
();

	localparam int Steps = CordicStepsDef;
	localparam int Latency = Steps + 7;

	typedef struct packed {
		logic signed [31:0] x, y, z;
		logic               clip;
	} rot_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic [15:0] turn_angle = '0;
	logic rotated_valid;
	logic rotated_stall = 1'b0;
	logic signed [31:0] rotated_x, rotated_y, rotated_z;
	logic clipped;

	rot_word_t expected_rot[$];
	int mismatches = 0;
	int points_sent = 0;
	int words_seen = 0;
	int clip_seen = 0;
	bit send_gaps = 1'b1;
	bit sink_gaps = 1'b1;

	axis_angle_vector_rotation dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.turn_angle(turn_angle),
		.rotated_valid(rotated_valid), .rotated_stall(rotated_stall),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
		.clipped(clipped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint floor_shift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint round_shift(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp32(longint v, ref bit clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic rot_word_t rotate_point(longint px, longint py, longint pz,
			longint ax, longint ay, longint az, logic [15:0] ang);
		longint cx, cy, cz, dx, dy, s, c, wx, wy, wz, tx, ty, tz;
		bit clip;
		rot_word_t r;
		clip = 1'b0;
		cz = longint'(ang) << 15;
		cx = 652032874;
		cy = 0;
		if (cz >= 1073741824) begin
			cx = 0;
			cy = 652032874;
			cz -= 1073741824;
		end
		for (int i = 0; i < Steps && i < AtanCount; i++) begin
			dx = floor_shift(cy, i);
			dy = floor_shift(cx, i);
			if (cz >= 0) begin
				cx -= dx;
				cy += dy;
				cz -= longint'(atan_val(i));
			end else begin
				cx += dx;
				cy -= dy;
				cz += longint'(atan_val(i));
			end
		end
		c = round_shift(cx, 6);
		s = round_shift(cy, 6);
		wx = round_shift(ax * s, 14);
		wy = round_shift(ay * s, 14);
		wz = round_shift(az * s, 14);
		tx = round_shift(wy * pz - wz * py, 23);
		ty = round_shift(wz * px - wx * pz, 23);
		tz = round_shift(wx * py - wy * px, 23);
		r.x = 32'(clamp32(px + round_shift(c * tx + wy * tz - wz * ty, 24), clip));
		r.y = 32'(clamp32(py + round_shift(c * ty + wz * tx - wx * tz, 24), clip));
		r.z = 32'(clamp32(pz + round_shift(c * tz + wx * ty - wy * tx, 24), clip));
		r.clip = clip;
		return r;
	endfunction

	// random idle at ~23 percent while gaps are enabled
	function automatic bit idle_now(bit en);
		return en && ($urandom_range(99) < 23);
	endfunction

	// valid stays up between back-to-back words; it drops only while idling
	task automatic send_point(logic signed [31:0] px, py, pz,
			logic signed [15:0] ax, ay, az, logic [15:0] ang);
		while (idle_now(send_gaps)) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		turn_angle <= ang;
		expected_rot.push_back(rotate_point(px, py, pz, ax, ay, az, ang));
		points_sent++;
		@(posedge clk);
		while (point_stall) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rotated_stall <= idle_now(sink_gaps);
		if (arst_n && rotated_valid && !rotated_stall) begin
			rot_word_t e;
			words_seen++;
			if (clipped) clip_seen++;
			if (expected_rot.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected rotated word at %0t", $realtime);
			end else begin
				e = expected_rot.pop_front();
				if (rotated_x !== e.x || rotated_y !== e.y || rotated_z !== e.z
						|| clipped !== e.clip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: exp %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
							words_seen, e.x, e.y, e.z, e.clip,
							rotated_x, rotated_y, rotated_z, clipped);
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return 32'($urandom_range(4095) - 2048);
			1: return 32'($urandom_range(32'h7fffff) - 32'h400000);
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] rand_axis();
		if ($urandom_range(9) == 0) return 16'($urandom);
		return 16'($urandom_range(32768) - 16384);
	endfunction

	task automatic test_directed();
		logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001};
		foreach (angs[i]) send_point(32'sd65536, 32'sd131072, -32'sd65536,
			16'sd0, 16'sd0, 16'sd16384, angs[i]);
		send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd16384, 16'sd0, 16'sd0, 16'h4000);
		send_point(32'h80000000, 32'h7fffffff, 32'h80000000, -16'sd16384, 16'sd0, 16'sd0, 16'h8000);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h6000);
		send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000, 16'hA000);
		send_point(32'h7fffffff, 32'h80000000, 32'sd0, 16'h7fff, 16'h8000, 16'sd0, 16'hFFFF);
		send_point(32'sd0, 32'sd0, 32'sd0, 16'sd9459, 16'sd9459, 16'sd9459, 16'h2AAA);
		send_point(-32'sd1, 32'sd1, 32'h5555aaaa, 16'sd0, 16'sd16384, 16'sd0, 16'h3FFF);
		send_point(32'h40000000, -32'h40000000, 32'sd12345, 16'sd11585, -16'sd11585, 16'sd0, 16'h7FFF);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			// middle stretch runs without any idling
			send_gaps = !(i >= count / 3 && i < count / 2);
			sink_gaps = send_gaps;
			send_point(rand_coord(), rand_coord(), rand_coord(),
				rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
		end
		send_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic drain();
		while (expected_rot.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(536);
		point_valid <= 1'b0;
		drain();
		$display("Rotated %0d points (%0d clipped) over all angle quadrants and extremes.",
			words_seen, clip_seen);
		if (mismatches == 0 && expected_rot.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ----- axis_angle_vector_rotation.f -----
rtl/core/aavr_pkg.sv
rtl/core/axis_angle_vector_rotation.sv
tb/tb_top.sv
